// ===== rtl/core/stag_pkg.sv =====
// Shared types, widths and register codes for the strided tensor address generator.
// No dependencies; every other file in rtl/core imports this package.
package stag_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int EXTENT_BITS = 16;
    localparam int OFFSET_BITS = 32;

    // Dimensions that have extent and stride registers behind them.
    localparam int NDIM_REGS   = 4;
    localparam int COORD_W     = 16;
    localparam int STRIDE_W    = 24;
    localparam int BASE_W      = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = COORD_W + STRIDE_W;
    localparam int SUM_W       = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + $clog2(MAX_DIMS + 1);

    localparam logic [COORD_W-1:0] EXT_MASK = COORD_W'((64'd1 << EXTENT_BITS) - 64'd1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_OUTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_INNER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE3   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd6;

    typedef enum logic [1:0] {
        OP_STEP    = 2'd0,
        OP_RESTART = 2'd1,
        OP_DIRECT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [STRIDE_W-1:0] stride_t;
    typedef logic [PROD_W-1:0]   prod_t;

    typedef coord_t [MAX_DIMS-1:0] coord_vec_t;
    typedef prod_t  [MAX_DIMS-1:0] prod_vec_t;

    // Decoded view configuration: extents already masked, zero turned into one.
    typedef struct packed {
        coord_t  [MAX_DIMS-1:0] extent;
        stride_t [MAX_DIMS-1:0] stride;
        logic    [BASE_W-1:0]   base;
    } cfg_t;

    // Request control that travels alongside the coordinates.
    typedef struct packed {
        op_t  op;
        logic range_err;
        logic last;
    } req_ctl_t;

endpackage

// ===== rtl/core/stag_cfg.sv =====
// Configuration register bank of the strided tensor address generator.
// Depends on stag_pkg for register codes and the decoded configuration struct.
module stag_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stag_pkg::CFG_W-1:0]      cfg_data,
    output stag_pkg::cfg_t                  cfg
);
    import stag_pkg::*;

    logic [CFG_W-1:0]  ext_outer_reg;
    logic [CFG_W-1:0]  ext_inner_reg;
    stride_t           stride_reg [NDIM_REGS];
    logic [BASE_W-1:0] base_reg;
    coord_t            raw_ext [NDIM_REGS];
    logic              wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_outer_reg <= 32'h0001_0001;
            ext_inner_reg <= 32'h0001_0001;
            stride_reg[0] <= '0;
            stride_reg[1] <= '0;
            stride_reg[2] <= '0;
            stride_reg[3] <= STRIDE_W'(1);
            base_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                CFG_EXT_OUTER: ext_outer_reg <= cfg_data;
                CFG_EXT_INNER: ext_inner_reg <= cfg_data;
                CFG_STRIDE0:   stride_reg[0] <= cfg_data[STRIDE_W-1:0];
                CFG_STRIDE1:   stride_reg[1] <= cfg_data[STRIDE_W-1:0];
                CFG_STRIDE2:   stride_reg[2] <= cfg_data[STRIDE_W-1:0];
                CFG_STRIDE3:   stride_reg[3] <= cfg_data[STRIDE_W-1:0];
                CFG_BASE:      base_reg      <= cfg_data[BASE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Masked extents; a zero extent behaves as one. Dimensions without
    // registers have extent one and stride zero.
    always_comb
    begin
        raw_ext[0] = ext_outer_reg[31:16] & EXT_MASK;
        raw_ext[1] = ext_outer_reg[15:0]  & EXT_MASK;
        raw_ext[2] = ext_inner_reg[31:16] & EXT_MASK;
        raw_ext[3] = ext_inner_reg[15:0]  & EXT_MASK;
        cfg.base   = base_reg;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (d < NDIM_REGS)
            begin
                cfg.extent[d] = (raw_ext[d] == '0) ? COORD_W'(1) : raw_ext[d];
                cfg.stride[d] = stride_reg[d];
            end
            else
            begin
                cfg.extent[d] = COORD_W'(1);
                cfg.stride[d] = '0;
            end
        end
    end

endmodule

// ===== rtl/core/stag_front.sv =====
// Request stage: walk odometer, coordinate selection and extent check.
// Depends on stag_pkg; feeds stag_mul through a registered stage.
module stag_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stag_pkg::cfg_t       cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stag_pkg::coord_vec_t out_coord,
    output stag_pkg::req_ctl_t   out_ctl
);
    import stag_pkg::*;

    logic       valid_reg;
    coord_vec_t walk_reg;
    coord_vec_t walk_next;
    coord_vec_t coord_reg;
    coord_vec_t coord_next;
    req_ctl_t   ctl_reg;
    req_ctl_t   ctl_next;
    op_t        op_in;
    logic       accept;
    logic       carry;
    logic       err;
    logic [COORD_W:0] inc;

    assign op_in     = op_t'(s_tuser);
    assign s_tready  = !valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;
    assign out_valid = valid_reg;
    assign out_coord = coord_reg;
    assign out_ctl   = ctl_reg;

    // Odometer: last dimension fastest, each coordinate wraps at its extent.
    // A stale coordinate at or above its extent wraps to zero on its turn.
    always_comb
    begin
        carry = 1'b1;
        for (int d = MAX_DIMS - 1; d >= 0; d--)
        begin
            inc = {1'b0, walk_reg[d]} + (COORD_W + 1)'(1);
            if (carry)
            begin
                if (inc >= {1'b0, cfg.extent[d]})
                begin
                    walk_next[d] = '0;
                end
                else
                begin
                    walk_next[d] = inc[COORD_W-1:0];
                    carry        = 1'b0;
                end
            end
            else
            begin
                walk_next[d] = walk_reg[d];
            end
        end
    end

    always_comb
    begin
        case (op_in)
            OP_STEP:
            begin
                coord_next = walk_reg;
            end
            OP_DIRECT:
            begin
                for (int d = 0; d < MAX_DIMS; d++)
                begin
                    coord_next[d] = (d < NDIM_REGS) ? s_tdata[COORD_W*(d % NDIM_REGS) +: COORD_W]
                                                    : '0;
                end
            end
            default:
            begin
                coord_next = '0;
            end
        endcase

        err = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            err = err | (coord_next[d] >= cfg.extent[d]);
        end

        ctl_next.op        = op_in;
        ctl_next.range_err = err;
        ctl_next.last      = (op_in == OP_STEP) && carry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            walk_reg  <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                valid_reg <= s_tvalid;
            end
            if (accept)
            begin
                case (op_in)
                    OP_STEP:    walk_reg <= walk_next;
                    OP_RESTART: walk_reg <= '0;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg <= coord_next;
            ctl_reg   <= ctl_next;
        end
    end

endmodule

// ===== rtl/core/stag_mul.sv =====
// Product stage: one coordinate-times-stride multiplier per dimension.
// Depends on stag_pkg; sits between stag_front and stag_sum.
module stag_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stag_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  stag_pkg::coord_vec_t in_coord,
    input  stag_pkg::req_ctl_t   in_ctl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stag_pkg::prod_vec_t  out_prod,
    output stag_pkg::req_ctl_t   out_ctl
);
    import stag_pkg::*;

    logic      valid_reg;
    prod_vec_t prod_reg;
    prod_vec_t prod_next;
    req_ctl_t  ctl_reg;
    logic      load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_ctl   = ctl_reg;

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            prod_next[d] = PROD_W'(in_coord[d]) * PROD_W'(cfg.stride[d]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            ctl_reg  <= in_ctl;
        end
    end

endmodule

// ===== rtl/core/stag_sum.sv =====
// Result stage: base plus products, overflow check and the output register.
// Depends on stag_pkg; drives the master-side stream of the top level.
module stag_sum (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stag_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  stag_pkg::prod_vec_t          in_prod,
    input  stag_pkg::req_ctl_t           in_ctl,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [stag_pkg::OFFSET_BITS-1:0] m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);
    import stag_pkg::*;

    logic                   valid_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    status_t                status_reg;
    status_t                status_next;
    logic                   last_reg;
    logic [SUM_W-1:0]       sum;
    logic                   ovf;
    logic                   load;

    assign in_ready = !valid_reg || m_tready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        sum = SUM_W'(cfg.base);
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            sum = sum + SUM_W'(in_prod[d]);
        end
        ovf = (sum >> OFFSET_BITS) != '0;

        offset_next = '0;
        status_next = ST_OK;
        if ((in_ctl.op == OP_STEP) || (in_ctl.op == OP_DIRECT))
        begin
            if (in_ctl.range_err)
            begin
                status_next = ST_RANGE;
            end
            else if (ovf)
            begin
                status_next = ST_OVERFLOW;
            end
            else
            begin
                offset_next = OFFSET_BITS'(sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            offset_reg <= offset_next;
            status_reg <= status_next;
            last_reg   <= in_ctl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = offset_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/core/strided_tensor_address_generator.sv =====
// Four-dimensional strided address generator, top level.
// Throughput: one request per cycle while the master side accepts results, set by
// the three-stage request/multiply/sum pipeline.
// Reset: rst_n clears the walk to the origin, empties the pipeline and loads the
// register defaults (extents one, strides 0/0/0/1, base zero).
// Depends on stag_pkg, stag_cfg, stag_front, stag_mul and stag_sum.
module strided_tensor_address_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stag_pkg::CFG_W-1:0]       cfg_data,
    // Request stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,  // coord_a[15:0], coord_b[31:16],
                                                       // coord_c[47:32], coord_d[63:48]
    input  logic [1:0]                       s_tuser,  // opcode[1:0]
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stag_pkg::OFFSET_BITS-1:0] m_tdata,  // offset[31:0]
    output logic [1:0]                       m_tuser,  // status[1:0]
    output logic                             m_tlast   // last_of_walk
);
    import stag_pkg::*;

    cfg_t       cfg;
    logic       a_valid;
    logic       a_ready;
    coord_vec_t a_coord;
    req_ctl_t   a_ctl;
    logic       b_valid;
    logic       b_ready;
    prod_vec_t  b_prod;
    req_ctl_t   b_ctl;

    // Register bank. Writes are expected only while no request is in flight,
    // so the pipeline reads the decoded values directly.
    stag_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage one: the walk odometer advances at the moment a step is accepted,
    // so consecutive steps see consecutive coordinates with no bubble.
    stag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_coord (a_coord),
        .out_ctl   (a_ctl)
    );

    // Stage two: four independent 16x24 multiplies.
    stag_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_coord  (a_coord),
        .in_ctl    (a_ctl),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_prod  (b_prod),
        .out_ctl   (b_ctl)
    );

    // Stage three: the sum against the offset width, then the output register.
    // Each stage accepts whenever it is empty or its content moves on, so a
    // held result does not stop earlier stages from filling.
    stag_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_prod  (b_prod),
        .in_ctl   (b_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/stag_checker.sv =====
// Port-level checks for the strided tensor address generator, bound to the top level.
// Depends on stag_pkg for the status codes.
module stag_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stag_pkg::OFFSET_BITS-1:0] m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             m_tlast
);
    import stag_pkg::*;

    // A held result keeps its contents while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result changed while stalled");

    // Any error status comes with a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata == '0)
    else $error("nonzero offset with error status");

    // No status code outside the defined set is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_RANGE) || (m_tuser == ST_OVERFLOW))
    else $error("undefined status code");

    // With the output register empty the whole pipeline can take a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind strided_tensor_address_generator stag_checker u_stag_checker (.*);

// ===== test/tb_strided_tensor_address_generator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the strided tensor address generator.
// It drives request and register-write transfers with random idling on both sides
// and checks every result transfer against its predictor or the directed table. Needs stag_pkg and the RTL.
module tb_strided_tensor_address_generator;
    import stag_pkg::*;

    // Opcode 3 has no meaning; the block must answer it with an all-zero result.
    localparam logic [1:0]           OP_UNUSED    = 2'd3;
    // Index 7 addresses no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;
    localparam int                   PIPE_LATENCY = 3;
    localparam int                   RANDOM_ITEMS = 1950;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   WALK_CAP     = 100;

    // One result transfer: offset on tdata, status on tuser, end of walk on tlast.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        status_t                status;
        logic                   last;
    } addr_result_t;

    // One row of the directed table: either a register write or a request.
    // Rows with typed set carry their expected result; the rest use the predictor.
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
        logic [1:0]           op;
        coord_vec_t           coords;
        logic                 typed;
        addr_result_t         result;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata   = '0;  // coord_a, coord_b, coord_c, coord_d
    logic [1:0]             s_tuser   = '0;  // opcode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OFFSET_BITS-1:0] m_tdata;         // offset
    logic [1:0]             m_tuser;         // status
    logic                   m_tlast;         // last_of_walk

    // Predictor copy of the view registers and of the walk odometer.
    logic [CFG_W-1:0]               ext_outer;
    logic [CFG_W-1:0]               ext_inner;
    stride_t [NDIM_REGS-1:0]        stride_reg;
    logic [BASE_W-1:0]              base_reg;
    coord_vec_t                     walk_pos;

    addr_result_t pending_results[$];
    stim_row_t    directed_rows[$];

    int s_gap_max   = 5;
    int m_stall_max = 5;
    int n_errors    = 0;
    int cycle_count = 0;
    int n_sent      = 0;
    int n_directed  = 0;
    int n_steps     = 0;
    int n_restarts  = 0;
    int n_directs   = 0;
    int n_unused    = 0;
    int n_walk_ends = 0;
    int n_range     = 0;
    int n_overflow  = 0;
    int n_settings  = 0;

    strided_tensor_address_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin : clock_gen
        forever #2 clk = ~clk;
    end

    // Extent of one dimension as the block sees it: masked field, zero read as one.
    function automatic logic [16:0] extent_of(int dim);
        logic [15:0] raw;
        case (dim)
            0:       raw = ext_outer[31:16];
            1:       raw = ext_outer[15:0];
            2:       raw = ext_inner[31:16];
            default: raw = ext_inner[15:0];
        endcase
        raw = raw & EXT_MASK;
        return (raw == '0) ? 17'd1 : {1'b0, raw};
    endfunction

    // Offset of a coordinate tuple. A coordinate outside its extent wins over an
    // overflow; the sum is formed wide so that an overflow cannot wrap unseen.
    function automatic addr_result_t locate_offset(coord_vec_t c);
        addr_result_t r;
        logic [63:0]  sum;
        int           dim;
        r.offset = '0;
        r.status = ST_OK;
        r.last   = 1'b0;
        for (dim = 0; dim < MAX_DIMS; dim++)
            if ({1'b0, c[dim]} >= extent_of(dim))
                r.status = ST_RANGE;
        if (r.status == ST_OK)
        begin
            sum = 64'(base_reg);
            for (dim = 0; dim < MAX_DIMS; dim++)
                sum += 64'(c[dim]) * 64'(stride_reg[dim]);
            if (sum[63:OFFSET_BITS] != '0)
                r.status = ST_OVERFLOW;
            else
                r.offset = sum[OFFSET_BITS-1:0];
        end
        return r;
    endfunction

    // Expected result of one accepted request; updates the walk like the block does.
    function automatic addr_result_t predict_address(logic [1:0] op, coord_vec_t coords);
        addr_result_t r;
        logic         carry;
        logic [16:0]  bumped;
        int           dim;
        r.offset = '0;
        r.status = ST_OK;
        r.last   = 1'b0;
        case (op)
            OP_STEP:
            begin
                r = locate_offset(walk_pos);
                // The odometer moves whatever the status; a stale coordinate
                // simply wraps to zero when its turn comes.
                carry = 1'b1;
                for (dim = MAX_DIMS - 1; dim >= 0 && carry; dim--)
                begin
                    bumped = {1'b0, walk_pos[dim]} + 17'd1;
                    if (bumped >= extent_of(dim))
                        walk_pos[dim] = '0;
                    else
                    begin
                        walk_pos[dim] = bumped[15:0];
                        carry = 1'b0;
                    end
                end
                r.last = carry;
            end
            OP_RESTART: walk_pos = '0;
            OP_DIRECT:  r = locate_offset(coords);
            default:    ;
        endcase
        return r;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.index  = idx;
        row.data   = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_req(logic [1:0] op, coord_t c0, coord_t c1, coord_t c2,
                                    coord_t c3, logic typed = 1'b0,
                                    logic [OFFSET_BITS-1:0] off = '0,
                                    status_t st = ST_OK, logic last = 1'b0);
        stim_row_t row;
        row               = '0;
        row.op            = op;
        row.coords        = {c3, c2, c1, c0};
        row.typed         = typed;
        row.result.offset = off;
        row.result.status = st;
        row.result.last   = last;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_extent();
        int r;
        r = $urandom_range(99, 0);
        if (r < 8)
            return 16'd0;
        if (r < 70)
            return 16'($urandom_range(4, 1));
        if (r < 92)
            return 16'($urandom_range(16, 5));
        return 16'($urandom());
    endfunction

    function automatic stride_t pick_stride();
        int r;
        r = $urandom_range(99, 0);
        if (r < 20)
            return '0;
        if (r < 60)
            return stride_t'($urandom_range(255, 1));
        if (r < 75)
            return '1;
        return stride_t'($urandom());
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        r = $urandom_range(99, 0);
        if (r < 25)
            return '0;
        if (r < 45)
            return BASE_W'($urandom_range(4095, 0));
        // Close to the top of the offset range, so that walks run into overflow.
        if (r < 75)
            return 32'hFFFF_FFFF - BASE_W'($urandom_range(262140, 0));
        return BASE_W'($urandom());
    endfunction

    // Stop sending and wait until every expected result has arrived, then give
    // the pipeline its latency so the block is idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic configure(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXT_OUTER: ext_outer     = data;
            CFG_EXT_INNER: ext_inner     = data;
            CFG_STRIDE0:   stride_reg[0] = data[STRIDE_W-1:0];
            CFG_STRIDE1:   stride_reg[1] = data[STRIDE_W-1:0];
            CFG_STRIDE2:   stride_reg[2] = data[STRIDE_W-1:0];
            CFG_STRIDE3:   stride_reg[3] = data[STRIDE_W-1:0];
            CFG_BASE:      base_reg      = data;
            default:       ;
        endcase
        @(posedge clk);
    endtask

    // One request transfer. The task returns at the accepting edge with tvalid
    // still high, so the caller must drive the next request or settle at once.
    task automatic send_request(input logic [1:0] op, input coord_vec_t coords,
                                input logic typed, input addr_result_t typed_result);
        int           gap;
        addr_result_t predicted;
        gap = $urandom_range(s_gap_max, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= coords;
        do @(posedge clk); while (s_tready !== 1'b1);
        predicted = predict_address(op, coords);
        pending_results.push_back(typed ? typed_result : predicted);
        n_sent++;
        case (op)
            OP_STEP:    n_steps++;
            OP_RESTART: n_restarts++;
            OP_DIRECT:  n_directs++;
            default:    n_unused++;
        endcase
        if (predicted.last)
            n_walk_ends++;
        if (predicted.status == ST_RANGE)
            n_range++;
        if (predicted.status == ST_OVERFLOW)
            n_overflow++;
    endtask

    // Result side: random stall before each transfer, then compare with the
    // oldest pending expectation.
    initial
    begin : result_sink
        int           stall;
        addr_result_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(m_stall_max, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: offset %h status %0d last %b",
                       m_tdata, m_tuser, m_tlast);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.offset)
                begin
                    $error("offset mismatch: expected %h, actual %h", want.offset, m_tdata);
                    n_errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    n_errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_walk mismatch: expected %b, actual %b", want.last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int         r;
        int         dim;
        int         walk_len;
        int         run_len;
        int         phase_end;
        coord_vec_t v;

        // Register defaults and an empty walk, as after reset.
        ext_outer  = 32'h0001_0001;
        ext_inner  = 32'h0001_0001;
        stride_reg = '0;
        stride_reg[3] = 24'd1;
        base_reg   = '0;
        walk_pos   = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With every extent one, a single step is the whole walk.
        add_req(OP_STEP,    16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h0, ST_OK, 1'b1);
        add_req(OP_DIRECT,  16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h0, ST_OK);
        add_req(OP_DIRECT,  16'h0, 16'h0, 16'h0, 16'h1, 1'b1, 32'h0, ST_RANGE);
        add_req(OP_UNUSED,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0, ST_OK);
        add_req(OP_RESTART, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 1'b1, 32'h0, ST_OK);
        // Largest outer extents, strides and base; dimension 2 extent written as zero.
        add_cfg(CFG_EXT_OUTER, 32'hFFFF_FFFF);
        add_cfg(CFG_EXT_INNER, 32'h0000_0003);
        add_cfg(CFG_STRIDE0,   32'hFFFF_FFFF);
        add_cfg(CFG_STRIDE1,   32'hFFFF_FFFF);
        add_cfg(CFG_STRIDE2,   32'hFFFF_FFFF);
        add_cfg(CFG_STRIDE3,   32'hFFFF_FFFF);
        add_cfg(CFG_BASE,      32'hFFFF_FFFF);
        add_req(OP_DIRECT, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'hFFFF_FFFF, ST_OK);
        add_req(OP_DIRECT, 16'hFFFE, 16'hFFFE, 16'h0, 16'h2, 1'b1, 32'h0, ST_OVERFLOW);
        // Out of range and overflowing at once: the range error must win.
        add_req(OP_DIRECT, 16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b1, 32'h0, ST_RANGE);
        add_req(OP_DIRECT, 16'h0, 16'h0, 16'h1, 16'h0, 1'b1, 32'h0, ST_RANGE);
        add_req(OP_STEP,   16'h0, 16'h0, 16'h0, 16'h0);
        add_req(OP_STEP,   16'h0, 16'h0, 16'h0, 16'h0);
        // Shrink the innermost extent under the walk, which now sits at 2.
        add_cfg(CFG_EXT_OUTER, 32'h0002_0000);
        add_cfg(CFG_EXT_INNER, 32'h0001_0002);
        add_cfg(CFG_STRIDE0,   32'h0000_1000);
        add_cfg(CFG_STRIDE1,   32'h0000_0000);
        add_cfg(CFG_STRIDE2,   32'h0000_0000);
        add_cfg(CFG_STRIDE3,   32'h0000_0001);
        add_cfg(CFG_BASE,      32'h0000_0100);
        add_req(OP_STEP, 16'h0, 16'h0, 16'h0, 16'h0);
        add_req(OP_STEP, 16'h0, 16'h0, 16'h0, 16'h0);
        add_req(OP_STEP, 16'h0, 16'h0, 16'h0, 16'h0);
        add_req(OP_STEP, 16'h0, 16'h0, 16'h0, 16'h0);
        add_cfg(CFG_SPARE, 32'h5A5A_A5A5);
        add_req(OP_DIRECT,  16'h1, 16'h0, 16'h0, 16'h1);
        add_req(OP_DIRECT,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0, ST_RANGE);
        add_req(OP_RESTART, 16'h0, 16'h0, 16'h0, 16'h0);
        add_req(OP_STEP,    16'h0, 16'h0, 16'h0, 16'h0);

        n_settings = 3;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                configure(directed_rows[i].index, directed_rows[i].data);
            else
                send_request(directed_rows[i].op, directed_rows[i].coords,
                             directed_rows[i].typed, directed_rows[i].result);
        end
        n_directed = n_sent;

        // Random phases: a fresh view setting, then mostly complete walks and
        // in-range direct requests, with some noise. The walk is not restarted
        // on a new setting, so stale coordinates come up on their own.
        while (n_sent - n_directed < RANDOM_ITEMS)
        begin
            case (n_settings % 4)
                0:       begin s_gap_max = 5; m_stall_max = 5; end
                1:       begin s_gap_max = 5; m_stall_max = 0; end
                2:       begin s_gap_max = 0; m_stall_max = 5; end
                default: begin s_gap_max = 0; m_stall_max = 0; end
            endcase
            configure(CFG_EXT_OUTER, {pick_extent(), pick_extent()});
            configure(CFG_EXT_INNER, {pick_extent(), pick_extent()});
            configure(CFG_STRIDE0, {8'($urandom()), pick_stride()});
            configure(CFG_STRIDE1, {8'($urandom()), pick_stride()});
            configure(CFG_STRIDE2, {8'($urandom()), pick_stride()});
            configure(CFG_STRIDE3, {8'($urandom()), pick_stride()});
            configure(CFG_BASE, pick_base());
            if ($urandom_range(7, 0) == 0)
                configure(CFG_SPARE, $urandom());
            n_settings++;

            walk_len = 1;
            for (dim = 0; dim < MAX_DIMS; dim++)
            begin
                walk_len = walk_len * int'(extent_of(dim));
                if (walk_len > WALK_CAP)
                    walk_len = WALK_CAP + 1;
            end

            phase_end = n_sent + $urandom_range(90, 40);
            while (n_sent < phase_end)
            begin
                r = $urandom_range(99, 0);
                v = {$urandom(), $urandom()};
                if (r < 55)
                begin
                    if ($urandom_range(1, 0) == 1)
                        send_request(OP_RESTART, v, 1'b0, '0);
                    run_len = (walk_len <= WALK_CAP) ? walk_len + $urandom_range(3, 0)
                                                    : $urandom_range(40, 8);
                    repeat (run_len)
                        send_request(OP_STEP, {$urandom(), $urandom()}, 1'b0, '0);
                end
                else if (r < 80)
                begin
                    for (dim = 0; dim < MAX_DIMS; dim++)
                        v[dim] = coord_t'($urandom_range(int'(extent_of(dim)) - 1, 0));
                    send_request(OP_DIRECT, v, 1'b0, '0);
                end
                else if (r < 90)
                    send_request(OP_DIRECT, v, 1'b0, '0);
                else if (r < 95)
                    send_request(OP_RESTART, v, 1'b0, '0);
                else
                    send_request(($urandom_range(1, 0) == 1) ? OP_UNUSED : OP_STEP,
                                 v, 1'b0, '0);
            end
        end

        settle();
        $display("Covered %0d requests (%0d step, %0d restart, %0d direct, %0d unused op)",
                 n_sent, n_steps, n_restarts, n_directs, n_unused);
        $display("over %0d view settings: %0d walk wraps, %0d range errors, %0d overflows.",
                 n_settings, n_walk_ends, n_range, n_overflow);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/stag_pkg.sv
rtl/core/stag_cfg.sv
rtl/core/stag_front.sv
rtl/core/stag_mul.sv
rtl/core/stag_sum.sv
rtl/core/strided_tensor_address_generator.sv
rtl/core/stag_checker.sv
test/tb_strided_tensor_address_generator.sv
